// ===== rtl/core/dmsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmsp_pkg: shared types and constants of the dual motor speed PID core
// Widths, command and register codes, datapath operations and controller
// states used by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package dmsp_pkg;

	// Motor count and derived index sizes
	localparam int NUM_MOTORS  = 2;
	localparam int MIDX_W      = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam int TICK_MOTORS = (NUM_MOTORS < 2) ? NUM_MOTORS : 2;
	localparam int SECOND_IDX  = (NUM_MOTORS > 1) ? 1 : 0;

	// Field and arithmetic widths
	localparam int GAIN_W    = 24;
	localparam int SPD_W     = 24;
	localparam int MAXSPD_W  = 23;
	localparam int ERR_W     = 25;
	localparam int DER_W     = 26;
	localparam int INT_W     = 40;
	localparam int CNT_W     = 16;
	localparam int DUTY_W    = 16;
	localparam int DRIVE_W   = 2;
	localparam int MUL_A_W   = GAIN_W + 1;
	localparam int MUL_B_W   = DER_W;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int ACC_W     = 66;
	localparam int FRAC_W    = 24;
	localparam int LIM_W     = DUTY_W + FRAC_W;
	localparam int U_W       = LIM_W + 1;
	localparam int SPD_SHIFT = 8;
	localparam int ILO_W     = 20;

	// Port widths
	localparam int CMD_W      = 2;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Command codes carried in the input tuser
	localparam logic [CMD_W-1:0] CMD_EDGE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TARGET = 2'd2;

	// Drive codes
	localparam logic [DRIVE_W-1:0] DRIVE_STOP = 2'd0;
	localparam logic [DRIVE_W-1:0] DRIVE_FWD  = 2'd1;
	localparam logic [DRIVE_W-1:0] DRIVE_REV  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY    = 3'd5;

	// Configuration reset values
	localparam logic [GAIN_W-1:0]   RST_GAIN_P      = 24'd3277;
	localparam logic [GAIN_W-1:0]   RST_GAIN_I      = 24'd3277;
	localparam logic [GAIN_W-1:0]   RST_GAIN_D      = 24'd0;
	localparam logic [GAIN_W-1:0]   RST_SPEED_SCALE = 24'd63842;
	localparam logic [MAXSPD_W-1:0] RST_SPEED_LIMIT = 23'd38400;
	localparam logic [DUTY_W-1:0]   RST_MAX_DUTY    = 16'd255;

	typedef struct packed {
		logic [GAIN_W-1:0]   gain_p;
		logic [GAIN_W-1:0]   gain_i;
		logic [GAIN_W-1:0]   gain_d;
		logic [GAIN_W-1:0]   speed_scale;
		logic [MAXSPD_W-1:0] speed_limit;
		logic [DUTY_W-1:0]   max_duty;
	} cfg_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_EDGE,
		OP_TARGET,
		OP_START,
		OP_SPD,
		OP_ERR,
		OP_DIFF,
		OP_MP,
		OP_MI_LO,
		OP_MI_HI,
		OP_MD,
		OP_SUM,
		OP_CLAMP,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		logic out_free;
		logic k_last;
	} dp_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPD,
		ST_ERR,
		ST_DIFF,
		ST_MP,
		ST_MI_LO,
		ST_MI_HI,
		ST_MD,
		ST_SUM,
		ST_CLAMP,
		ST_OUT
	} ctrl_state_t;

endpackage

// ===== rtl/core/dmsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmsp_ctrl: sequencer of the dual motor speed PID core
// Takes input transactions, dispatches edges and targets at once and walks
// the datapath through the per-motor tick sequence.
// ----------------------------------------------------------------------------
module dmsp_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_accept,
	input  logic [dmsp_pkg::CMD_W-1:0]  in_cmd,
	input  dmsp_pkg::dp_status_t        status,
	output logic                        in_ready,
	output dmsp_pkg::dp_op_t            op
);
	import dmsp_pkg::*;

	ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && in_cmd == CMD_TICK) begin
					state_nxt = ST_SPD;
				end
			end
			ST_SPD:   state_nxt = ST_ERR;
			ST_ERR:   state_nxt = ST_DIFF;
			ST_DIFF:  state_nxt = ST_MP;
			ST_MP:    state_nxt = ST_MI_LO;
			ST_MI_LO: state_nxt = ST_MI_HI;
			ST_MI_HI: state_nxt = ST_MD;
			ST_MD:    state_nxt = ST_SUM;
			ST_SUM:   state_nxt = ST_CLAMP;
			ST_CLAMP: state_nxt = ST_OUT;
			ST_OUT: begin
				if (status.out_free) begin
					state_nxt = status.k_last ? ST_IDLE : ST_SPD;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Accept input only between ticks
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		op = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					case (in_cmd)
						CMD_EDGE:   op = OP_EDGE;
						CMD_TARGET: op = OP_TARGET;
						CMD_TICK:   op = OP_START;
						default:    op = OP_NONE;
					endcase
				end
			end
			ST_SPD:   op = OP_SPD;
			ST_ERR:   op = OP_ERR;
			ST_DIFF:  op = OP_DIFF;
			ST_MP:    op = OP_MP;
			ST_MI_LO: op = OP_MI_LO;
			ST_MI_HI: op = OP_MI_HI;
			ST_MD:    op = OP_MD;
			ST_SUM:   op = OP_SUM;
			ST_CLAMP: op = OP_CLAMP;
			ST_OUT:   op = status.out_free ? OP_OUT : OP_NONE;
			default:  op = OP_NONE;
		endcase
	end

endmodule

// ===== rtl/core/dmsp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmsp_dp: datapath of the dual motor speed PID core
// Per-motor state, one shared signed multiplier, the PID accumulator, the
// output clamp and rounding, and the result register.
// ----------------------------------------------------------------------------
module dmsp_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dmsp_pkg::dp_op_t                   op,
	input  dmsp_pkg::cfg_t                     cfg,
	input  logic                               motor,
	input  logic                               phase_a,
	input  logic signed [dmsp_pkg::SPD_W-1:0]  target_first,
	input  logic signed [dmsp_pkg::SPD_W-1:0]  target_second,
	input  logic                               out_ready,
	output dmsp_pkg::dp_status_t               status,
	output logic                               out_valid,
	output logic                               out_motor_index,
	output logic [dmsp_pkg::DRIVE_W-1:0]       out_drive,
	output logic [dmsp_pkg::DUTY_W-1:0]        out_duty,
	output logic signed [dmsp_pkg::SPD_W-1:0]  out_speed,
	output logic                               out_last
);
	import dmsp_pkg::*;

	function automatic logic signed [ACC_W-1:0] acc_ext(input logic signed [PROD_W-1:0] v);
		return {{(ACC_W-PROD_W){v[PROD_W-1]}}, v};
	endfunction

	function automatic logic signed [SPD_W-1:0] clamp_tgt(
		input logic signed [SPD_W-1:0] t,
		input logic [MAXSPD_W-1:0]     ms
	);
		logic signed [SPD_W-1:0] pos;
		logic signed [SPD_W-1:0] neg;
		pos = $signed({1'b0, ms});
		neg = -pos;
		if (t > pos) begin
			return pos;
		end else if (t < neg) begin
			return neg;
		end
		return t;
	endfunction

	// Per-motor state
	logic signed [CNT_W-1:0] pulse_q     [NUM_MOTORS];
	logic signed [INT_W-1:0] integ_sum_q [NUM_MOTORS];
	logic signed [ERR_W-1:0] prev_err_q  [NUM_MOTORS];
	logic signed [SPD_W-1:0] target_q    [NUM_MOTORS];

	logic [MIDX_W-1:0] k_q;
	logic [MIDX_W-1:0] enc_idx;
	logic [MIDX_W-1:0] pulse_idx;
	logic              enc_ok;
	logic signed [CNT_W-1:0] pulse_rd;

	// Tick working registers
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SPD_W-1:0]  speed_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [DER_W-1:0]  deriv_q;
	logic signed [INT_W-1:0]  integ_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [U_W-1:0]    u_q;

	logic out_valid_q;

	assign enc_idx   = MIDX_W'(motor);
	assign enc_ok    = int'(motor) < NUM_MOTORS;
	assign pulse_idx = (op == OP_EDGE) ? enc_idx : k_q;
	assign pulse_rd  = pulse_q[pulse_idx];

	assign status.out_free = !out_valid_q || out_ready;
	assign status.k_last   = (int'(k_q) == TICK_MOTORS - 1);

	// Shared multiplier operand select
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			OP_SPD: begin
				mul_a = $signed({1'b0, cfg.speed_scale});
				mul_b = {{(MUL_B_W-CNT_W){pulse_rd[CNT_W-1]}}, pulse_rd};
			end
			OP_MP: begin
				mul_a = $signed({1'b0, cfg.gain_p});
				mul_b = {{(MUL_B_W-ERR_W){err_q[ERR_W-1]}}, err_q};
			end
			OP_MI_LO: begin
				mul_a = $signed({1'b0, cfg.gain_i});
				mul_b = $signed({{(MUL_B_W-ILO_W){1'b0}}, integ_q[ILO_W-1:0]});
			end
			OP_MI_HI: begin
				mul_a = $signed({1'b0, cfg.gain_i});
				mul_b = {{(MUL_B_W-(INT_W-ILO_W)){integ_q[INT_W-1]}}, integ_q[INT_W-1:ILO_W]};
			end
			OP_MD: begin
				mul_a = $signed({1'b0, cfg.gain_d});
				mul_b = deriv_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Speed saturation from the scaled pulse product
	logic signed [PROD_W-1:0] speed_full;
	logic signed [SPD_W-1:0]  speed_sat;
	logic [PROD_W-SPD_W:0]    speed_hi;

	assign speed_full = prod_q >>> SPD_SHIFT;
	assign speed_hi   = speed_full[PROD_W-1:SPD_W-1];

	always_comb begin
		if (speed_hi == '0 || speed_hi == '1) begin
			speed_sat = speed_full[SPD_W-1:0];
		end else if (speed_full[PROD_W-1]) begin
			speed_sat = {1'b1, {(SPD_W-1){1'b0}}};
		end else begin
			speed_sat = {1'b0, {(SPD_W-1){1'b1}}};
		end
	end

	// Error, derivative and saturated integral
	logic signed [ERR_W-1:0] err_nxt;
	logic signed [DER_W-1:0] deriv_nxt;
	logic signed [INT_W:0]   isum;
	logic signed [INT_W-1:0] integ_nxt;
	logic signed [SPD_W-1:0] tgt_rd;
	logic signed [ERR_W-1:0] prev_rd;
	logic signed [INT_W-1:0] isum_rd;

	assign tgt_rd  = target_q[k_q];
	assign prev_rd = prev_err_q[k_q];
	assign isum_rd = integ_sum_q[k_q];

	always_comb begin
		err_nxt   = {tgt_rd[SPD_W-1], tgt_rd} - {speed_q[SPD_W-1], speed_q};
		deriv_nxt = {err_nxt[ERR_W-1], err_nxt} - {prev_rd[ERR_W-1], prev_rd};
		isum      = {isum_rd[INT_W-1], isum_rd}
			+ {{(INT_W+1-ERR_W){err_nxt[ERR_W-1]}}, err_nxt};
		if (isum[INT_W] == isum[INT_W-1]) begin
			integ_nxt = isum[INT_W-1:0];
		end else if (isum[INT_W]) begin
			integ_nxt = {1'b1, {(INT_W-1){1'b0}}};
		end else begin
			integ_nxt = {1'b0, {(INT_W-1){1'b1}}};
		end
	end

	// Output limit and clamp
	logic [LIM_W-1:0]        lim;
	logic signed [ACC_W-1:0] lim_pos;
	logic signed [ACC_W-1:0] lim_neg;
	logic                    over;
	logic                    under;
	logic signed [U_W-1:0]   u_nxt;

	assign lim     = {cfg.max_duty, {FRAC_W{1'b0}}};
	assign lim_pos = $signed({{(ACC_W-LIM_W){1'b0}}, lim});
	assign lim_neg = -lim_pos;
	assign over    = acc_q > lim_pos;
	assign under   = acc_q < lim_neg;

	always_comb begin
		if (over) begin
			u_nxt = lim_pos[U_W-1:0];
		end else if (under) begin
			u_nxt = lim_neg[U_W-1:0];
		end else begin
			u_nxt = acc_q[U_W-1:0];
		end
	end

	// Rounding of the clamped output to the duty
	logic [U_W-1:0]    mag;
	logic [U_W-1:0]    rnd;
	logic [DUTY_W-1:0] duty_nxt;
	logic [DRIVE_W-1:0] drive_nxt;

	always_comb begin
		mag      = u_q[U_W-1] ? U_W'(-u_q) : U_W'(u_q);
		rnd      = mag + (U_W'(1) << (FRAC_W - 1));
		duty_nxt = rnd[FRAC_W +: DUTY_W];
		if (duty_nxt == '0) begin
			drive_nxt = DRIVE_STOP;
		end else if (u_q[U_W-1]) begin
			drive_nxt = DRIVE_REV;
		end else begin
			drive_nxt = DRIVE_FWD;
		end
	end

	// Per-motor state and motor counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				pulse_q[i]     <= '0;
				integ_sum_q[i] <= '0;
				prev_err_q[i]  <= '0;
				target_q[i]    <= '0;
			end
			k_q <= '0;
		end else begin
			case (op)
				OP_EDGE: begin
					if (enc_ok) begin
						pulse_q[enc_idx] <= phase_a ? pulse_rd + CNT_W'(1)
							: pulse_rd - CNT_W'(1);
					end
				end
				OP_TARGET: begin
					target_q[0] <= clamp_tgt(target_first, cfg.speed_limit);
					if (NUM_MOTORS > 1) begin
						target_q[SECOND_IDX] <= clamp_tgt(target_second, cfg.speed_limit);
					end
				end
				OP_START: k_q <= '0;
				OP_CLAMP: begin
					if (!over && !under) begin
						integ_sum_q[k_q] <= integ_q;
					end
					prev_err_q[k_q] <= err_q;
					pulse_q[k_q]    <= '0;
				end
				OP_OUT: k_q <= k_q + MIDX_W'(1);
				default: ;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		prod_q <= prod;
		case (op)
			OP_ERR: speed_q <= speed_sat;
			OP_DIFF: begin
				err_q   <= err_nxt;
				deriv_q <= deriv_nxt;
				integ_q <= integ_nxt;
			end
			OP_MI_LO: acc_q <= acc_ext(prod_q);
			OP_MI_HI: acc_q <= acc_q + acc_ext(prod_q);
			OP_MD:    acc_q <= acc_q + (acc_ext(prod_q) <<< ILO_W);
			OP_SUM:   acc_q <= acc_q + acc_ext(prod_q);
			OP_CLAMP: u_q   <= u_nxt;
			default: ;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_OUT) begin
			out_motor_index <= k_q[0];
			out_drive       <= drive_nxt;
			out_duty        <= duty_nxt;
			out_speed       <= speed_q;
			out_last        <= status.k_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/dual_motor_speed_pid_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_speed_pid_core: two-motor encoder speed regulator with PID
// Counts encoder edges, holds target speeds and runs a PID step with
// conditional anti-windup for each motor on every sample tick.
//
// Usage:
//   s_axis carries one command per transaction (tuser): encoder edge,
//   sample tick or set targets. Edges and targets are absorbed in the
//   accept cycle and produce nothing, so they stream at one per clock between ticks.
//   A tick computes both motors in turn and emits two transactions on
//   m_axis, motor one first, tlast on the second.
//   Each motor runs the shared 25x26 multiplier sequence:
//   one multiply for the speed, four for the P, I (split in two halves)
//   and D terms, then accumulate, clamp and round. A tick occupies the
//   core for both motors plus any output stall; s_axis_tready stays low
//   during that time.
//   The result register holds a finished transaction until it is taken;
//   a stalled receiver only halts the sequence at the point where the
//   next result would be loaded.
//   The cfg channel is always ready and writes one register per
//   transaction; write it only while the core is idle.
//   Reset clears counts, integrals, errors and targets and restores the
//   register defaults.
// ----------------------------------------------------------------------------
module dual_motor_speed_pid_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// motor[0], phase_a[1], target_first[25:2], target_second[49:26], zero[55:50]
	input  logic [dmsp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// command[1:0]
	input  logic [dmsp_pkg::CMD_W-1:0]           s_axis_tuser,
	// result stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// drive[1:0], duty[17:2], measured_speed[41:18], zero[47:42]
	output logic [dmsp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// motor_index[0]
	output logic                                 m_axis_tuser,
	output logic                                 m_axis_tlast,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dmsp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dmsp_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import dmsp_pkg::*;

	cfg_t       cfg_q;
	dp_op_t     op;
	dp_status_t status;
	logic       in_accept;

	logic [DRIVE_W-1:0]      out_drive;
	logic [DUTY_W-1:0]       out_duty;
	logic signed [SPD_W-1:0] out_speed;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// Register bank; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p      <= RST_GAIN_P;
			cfg_q.gain_i      <= RST_GAIN_I;
			cfg_q.gain_d      <= RST_GAIN_D;
			cfg_q.speed_scale <= RST_SPEED_SCALE;
			cfg_q.speed_limit <= RST_SPEED_LIMIT;
			cfg_q.max_duty    <= RST_MAX_DUTY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_P:      cfg_q.gain_p      <= cfg_data;
				REG_GAIN_I:      cfg_q.gain_i      <= cfg_data;
				REG_GAIN_D:      cfg_q.gain_d      <= cfg_data;
				REG_SPEED_SCALE: cfg_q.speed_scale <= cfg_data;
				REG_SPEED_LIMIT: cfg_q.speed_limit <= cfg_data[MAXSPD_W-1:0];
				REG_MAX_DUTY:    cfg_q.max_duty    <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	dmsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_cmd    (s_axis_tuser),
		.status    (status),
		.in_ready  (s_axis_tready),
		.op        (op)
	);

	dmsp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.op              (op),
		.cfg             (cfg_q),
		.motor           (s_axis_tdata[0]),
		.phase_a         (s_axis_tdata[1]),
		.target_first    ($signed(s_axis_tdata[2 +: SPD_W])),
		.target_second   ($signed(s_axis_tdata[2 + SPD_W +: SPD_W])),
		.out_ready       (m_axis_tready),
		.status          (status),
		.out_valid       (m_axis_tvalid),
		.out_motor_index (m_axis_tuser),
		.out_drive       (out_drive),
		.out_duty        (out_duty),
		.out_speed       (out_speed),
		.out_last        (m_axis_tlast)
	);

	// Pack the result fields, lowest first, zero padded to whole bytes
	assign m_axis_tdata = {
		{(OUT_DATA_W - DRIVE_W - DUTY_W - SPD_W){1'b0}},
		out_speed,
		out_duty,
		out_drive
	};

endmodule

// ===== tb/sv/dual_motor_speed_pid_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_speed_pid_core_test: self-checking bench for the speed PID core
// Drives encoder edges, target updates, sample ticks and unknown commands
// into the core under random idling on both streams. A behavioral copy of
// the regulator predicts every drive result, and each result transaction is
// checked field by field. A directed table comes first, then a back-to-back
// edge run, then random traffic over several register settings, extremes
// included.
// ----------------------------------------------------------------------------
module dual_motor_speed_pid_core_test;
	import dmsp_pkg::*;

	// Command code the core must ignore
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	// Register indexes past the end of the list, writes must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam int     PHASES        = 8;
	localparam int     PHASE_ITEMS   = 220;
	localparam int     RUN_EDGES     = 200;
	localparam int     SETTLE_CYCLES = 30;
	localparam longint CYCLE_LIMIT   = 2_000_000;

	// Saturation bounds of the regulator arithmetic
	localparam longint SPEED_HI = 64'sd8388607;
	localparam longint SPEED_LO = -64'sd8388608;
	localparam longint INTEG_HI = 64'sd549755813887;
	localparam longint INTEG_LO = -64'sd549755813888;
	localparam longint TERM_CAP = 64'sd1152921504606846976;
	localparam longint HALF_LSB = 64'sd8388608;

	// One drive result as it leaves the core
	typedef struct packed {
		logic                    mtr;
		logic [DRIVE_W-1:0]      drive;
		logic [DUTY_W-1:0]       duty;
		logic signed [SPD_W-1:0] speed;
		logic                    last;
	} drive_res_t;

	// One row of the directed table; typed rows carry their expected drive
	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic               mtr;
		logic               phase_a;
		logic [SPD_W-1:0]   tgt_a;
		logic [SPD_W-1:0]   tgt_b;
		logic               typed;
		logic [DRIVE_W-1:0] exp_drive;
		logic [DUTY_W-1:0]  exp_duty;
		logic [SPD_W-1:0]   exp_speed;
	} dir_row_t;

	localparam int DIR_COUNT = 18;
	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		// first tick after reset: nothing counted, nothing targeted
		'{CMD_TICK,    1'b0, 1'b0, 24'h000000, 24'h000000, 1'b1, DRIVE_STOP, 16'd0, 24'h000000},
		// unknown command with every data bit set: no effect
		'{CMD_UNKNOWN, 1'b1, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		// tick with junk in its unused fields: still all zero
		'{CMD_TICK,    1'b1, 1'b1, 24'hFFFFFF, 24'h800000, 1'b1, DRIVE_STOP, 16'd0, 24'h000000},
		'{CMD_EDGE,    1'b0, 1'b1, 24'h000000, 24'h000000, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		'{CMD_EDGE,    1'b0, 1'b1, 24'h800000, 24'h7FFFFF, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		'{CMD_EDGE,    1'b1, 1'b0, 24'hFFFFFF, 24'h000000, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		// targets at both ends of the field, clamped to max speed
		'{CMD_TARGET,  1'b1, 1'b1, 24'h7FFFFF, 24'h800000, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		'{CMD_TICK,    1'b0, 1'b0, 24'h000000, 24'h000000, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		'{CMD_EDGE,    1'b1, 1'b1, 24'h000000, 24'h000000, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		'{CMD_EDGE,    1'b1, 1'b1, 24'h000000, 24'h000000, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		'{CMD_EDGE,    1'b0, 1'b0, 24'h000000, 24'h000000, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		// targets exactly at the clamp
		'{CMD_TARGET,  1'b0, 1'b0, 24'hFF6A00, 24'h009600, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		'{CMD_TICK,    1'b0, 1'b0, 24'h000000, 24'h000000, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		// one past the clamp on each side
		'{CMD_TARGET,  1'b0, 1'b0, 24'h009601, 24'hFF69FF, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		'{CMD_TICK,    1'b0, 1'b0, 24'h000000, 24'h000000, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		'{CMD_TARGET,  1'b1, 1'b1, 24'h000000, 24'h000000, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		'{CMD_TICK,    1'b0, 1'b0, 24'h000000, 24'h000000, 1'b0, DRIVE_STOP, 16'd0, 24'h000000},
		'{CMD_TICK,    1'b0, 1'b0, 24'h000000, 24'h000000, 1'b0, DRIVE_STOP, 16'd0, 24'h000000}
	};

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [CMD_W-1:0]      s_axis_tuser  = CMD_EDGE;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = REG_GAIN_P;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	// Mirror of the register file
	longint cfg_gain_p, cfg_gain_i, cfg_gain_d, cfg_speed_scale, cfg_speed_limit, cfg_max_duty;

	// Mirror of the per-motor regulator state
	logic signed [CNT_W-1:0] enc_count [NUM_MOTORS];
	longint integ_sum [NUM_MOTORS];
	longint last_err  [NUM_MOTORS];
	longint tgt_speed [NUM_MOTORS];

	drive_res_t expected_drives [$];
	int         mismatches  = 0;
	longint     cycle_count = 0;
	bit         quiet       = 1'b0;   // suppress idling on both streams
	bit         in_held     = 1'b0;   // s_axis_tvalid currently high
	bit         out_held    = 1'b0;   // m_axis_tready currently high

	always #1 clk = ~clk;

	dual_motor_speed_pid_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 6);
	endfunction

	// Pick a target: full-range noise, the clamp edges, one past the upper edge, or a value inside the clamp
	function automatic logic [SPD_W-1:0] pick_target();
		case ($urandom_range(0, 5))
		0: return SPD_W'($urandom);
		1: return SPD_W'(cfg_speed_limit);
		2: return SPD_W'(-cfg_speed_limit);
		3: return SPD_W'(cfg_speed_limit + 1);
		default: return SPD_W'(longint'($urandom_range(0, 32'(2 * cfg_speed_limit)))
				- cfg_speed_limit);
		endcase
	endfunction

	// Advance the regulator copy by one input item and return the drives it causes
	task automatic regulate_item(input logic [CMD_W-1:0] cmd, input logic mtr, input logic ph,
			input logic signed [SPD_W-1:0] ta, input logic signed [SPD_W-1:0] tb,
			output drive_res_t res [2], output int n);
		longint lim, spd, err, integ, tp, ti, td, u, mag, dty;
		n = 0;
		case (cmd)
		CMD_EDGE: enc_count[mtr] = enc_count[mtr] + (ph ? 16'sd1 : -16'sd1);
		CMD_TARGET: begin
			tgt_speed[0] = clip(longint'(ta), -cfg_speed_limit, cfg_speed_limit);
			tgt_speed[SECOND_IDX] = clip(longint'(tb), -cfg_speed_limit, cfg_speed_limit);
		end
		CMD_TICK: begin
			for (int k = 0; k < TICK_MOTORS; k++) begin
				lim   = cfg_max_duty <<< FRAC_W;
				spd   = clip((longint'(enc_count[k]) * cfg_speed_scale) >>> SPD_SHIFT,
						SPEED_LO, SPEED_HI);
				err   = tgt_speed[k] - spd;
				integ = clip(integ_sum[k] + err, INTEG_LO, INTEG_HI);
				tp    = clip(cfg_gain_p * err, -TERM_CAP, TERM_CAP);
				ti    = clip(cfg_gain_i * integ, -TERM_CAP, TERM_CAP);
				td    = clip(cfg_gain_d * (err - last_err[k]), -TERM_CAP, TERM_CAP);
				u     = tp + ti + td;
				// anti-windup: keep the old sum while the raw output is out of range
				if (u <= lim && u >= -lim) begin
					integ_sum[k] = integ;
				end
				u   = clip(u, -lim, lim);
				mag = (u < 0) ? -u : u;
				dty = (mag + HALF_LSB) >>> FRAC_W;
				res[n].mtr   = k[0];
				res[n].drive = (dty == 0) ? DRIVE_STOP : ((u > 0) ? DRIVE_FWD : DRIVE_REV);
				res[n].duty  = dty[DUTY_W-1:0];
				res[n].speed = spd[SPD_W-1:0];
				res[n].last  = (k == TICK_MOTORS - 1);
				last_err[k]  = err;
				enc_count[k] = '0;
				n++;
			end
		end
		default: ;
		endcase
	endtask

	// Drop the input valid if it is still up from the last transaction
	task automatic idle_in();
		if (in_held) begin
			s_axis_tvalid <= 1'b0;
			in_held = 1'b0;
		end
	endtask

	// Offer one item, wait for its transaction, then queue what it should produce
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic mtr, input logic ph,
			input logic [SPD_W-1:0] ta, input logic [SPD_W-1:0] tb, input bit typed = 1'b0,
			input logic [DRIVE_W-1:0] t_drive = DRIVE_STOP,
			input logic [DUTY_W-1:0] t_duty = '0, input logic [SPD_W-1:0] t_speed = '0);
		drive_res_t res [2];
		int n, gap;
		gap = draw_gap();
		if (gap > 0) begin
			idle_in();
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		in_held = 1'b1;
		s_axis_tdata <= {{(IN_DATA_W-2-2*SPD_W){1'b0}}, tb, ta, ph, mtr};
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		regulate_item(cmd, mtr, ph, ta, tb, res, n);
		for (int i = 0; i < n; i++) begin
			if (typed) begin
				res[i].drive = t_drive;
				res[i].duty  = t_duty;
				res[i].speed = t_speed;
			end
			expected_drives.push_back(res[i]);
		end
	endtask

	// Write one register; the caller drops cfg_valid after the last write
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		REG_GAIN_P:      cfg_gain_p      = data;
		REG_GAIN_I:      cfg_gain_i      = data;
		REG_GAIN_D:      cfg_gain_d      = data;
		REG_SPEED_SCALE: cfg_speed_scale = data;
		REG_SPEED_LIMIT: cfg_speed_limit = data[MAXSPD_W-1:0];
		REG_MAX_DUTY:    cfg_max_duty    = data[DUTY_W-1:0];
		default: ;
		endcase
	endtask

	// Hold off input until every queued drive has come out, then let the core settle
	task automatic drain();
		idle_in();
		while (expected_drives.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: hold each offered result for a random number of cycles
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				if (out_held) begin
					m_axis_tready <= 1'b0;
					out_held = 1'b0;
				end
				do @(posedge clk); while (!m_axis_tvalid);
				repeat (stall - 1) @(posedge clk);
			end
			if (!out_held) begin
				m_axis_tready <= 1'b1;
				out_held = 1'b1;
			end
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Check every result transaction against the oldest queued drive
	always @(posedge clk) begin
		drive_res_t want;
		drive_res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.mtr   = m_axis_tuser;
			got.drive = m_axis_tdata[1:0];
			got.duty  = m_axis_tdata[17:2];
			got.speed = m_axis_tdata[41:18];
			got.last  = m_axis_tlast;
			if (expected_drives.size() == 0) begin
				$error("result transaction with nothing expected, motor_index %0d", got.mtr);
				mismatches++;
			end else begin
				want = expected_drives.pop_front();
				if (got.mtr !== want.mtr) begin
					$error("motor_index: expected %0d, actual %0d", want.mtr, got.mtr);
					mismatches++;
				end
				if (got.drive !== want.drive) begin
					$error("drive: expected %0d, actual %0d", want.drive, got.drive);
					mismatches++;
				end
				if (got.duty !== want.duty) begin
					$error("duty: expected %0d, actual %0d", want.duty, got.duty);
					mismatches++;
				end
				if (got.speed !== want.speed) begin
					$error("measured_speed: expected %0d, actual %0d", want.speed, got.speed);
					mismatches++;
				end
				if (got.last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, got.last);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		cfg_t setting;
		int   sent, pick, burst, trend, focus;
		cfg_gain_p      = RST_GAIN_P;
		cfg_gain_i      = RST_GAIN_I;
		cfg_gain_d      = RST_GAIN_D;
		cfg_speed_scale = RST_SPEED_SCALE;
		cfg_speed_limit = RST_SPEED_LIMIT;
		cfg_max_duty    = RST_MAX_DUTY;
		for (int k = 0; k < NUM_MOTORS; k++) begin
			enc_count[k] = '0;
			integ_sum[k] = 0;
			last_err[k]  = 0;
			tgt_speed[k] = 0;
		end

		// Hold reset once, at the start
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, register defaults
		for (int i = 0; i < DIR_COUNT; i++) begin
			send_item(DIR_ROWS[i].cmd, DIR_ROWS[i].mtr, DIR_ROWS[i].phase_a,
					DIR_ROWS[i].tgt_a, DIR_ROWS[i].tgt_b, DIR_ROWS[i].typed,
					DIR_ROWS[i].exp_drive, DIR_ROWS[i].exp_duty, DIR_ROWS[i].exp_speed);
		end

		// Back-to-back edge run: motor one counts up, motor two down
		quiet = 1'b1;
		for (int e = 0; e < RUN_EDGES; e++) begin
			send_item(CMD_EDGE, e[0], ~e[0], SPD_W'($urandom), SPD_W'($urandom));
		end
		quiet = 1'b0;
		send_item(CMD_TICK, 1'b0, 1'b0, '0, '0);

		// Random traffic under a new register setting per phase
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
			0: begin
				setting.gain_p      = 24'd3277;
				setting.gain_i      = 24'd3277;
				setting.gain_d      = 24'd1638;
				setting.speed_scale = 24'd63842;
				setting.speed_limit = 23'd38400;
				setting.max_duty    = 16'd255;
			end
			1: begin
				setting.gain_p      = '1;
				setting.gain_i      = '1;
				setting.gain_d      = '1;
				setting.speed_scale = '1;
				setting.speed_limit = '1;
				setting.max_duty    = '1;
			end
			// zero limit: every output must come out stopped
			2: setting = '0;
			3: begin
				setting.gain_p      = 24'd65536;
				setting.gain_i      = 24'd655;
				setting.gain_d      = 24'd0;
				setting.speed_scale = 24'd256;
				setting.speed_limit = 23'd2000;
				setting.max_duty    = 16'd1;
			end
			default: begin
				setting.gain_p = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom)
						: GAIN_W'($urandom_range(0, 20000));
				setting.gain_i = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom)
						: GAIN_W'($urandom_range(0, 20000));
				setting.gain_d = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom)
						: GAIN_W'($urandom_range(0, 20000));
				setting.speed_scale = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom)
						: GAIN_W'($urandom_range(1000, 200000));
				setting.speed_limit = ($urandom_range(0, 3) == 0) ? MAXSPD_W'($urandom)
						: MAXSPD_W'($urandom_range(1000, 100000));
				setting.max_duty = ($urandom_range(0, 3) == 0) ? DUTY_W'($urandom)
						: DUTY_W'($urandom_range(1, 1023));
			end
			endcase
			// Junk in the bits above a narrow register must be dropped
			put_reg(REG_GAIN_P, setting.gain_p);
			put_reg(REG_GAIN_I, setting.gain_i);
			put_reg(REG_GAIN_D, setting.gain_d);
			put_reg(REG_SPEED_SCALE, setting.speed_scale);
			put_reg(REG_SPEED_LIMIT, {1'($urandom), setting.speed_limit});
			put_reg(REG_MAX_DUTY, {8'($urandom), setting.max_duty});
			put_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
			put_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
			cfg_valid <= 1'b0;

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					// Well-formed sample period: a run of edges, maybe new targets, a tick
					quiet = ($urandom_range(0, 5) == 0);
					burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
							: $urandom_range(0, 20);
					trend = $urandom_range(0, 2);
					focus = $urandom_range(0, 2);
					for (int e = 0; e < burst; e++) begin
						send_item(CMD_EDGE, (focus == 2) ? 1'($urandom) : focus[0],
								(trend == 2) ? 1'($urandom) : (trend == 0),
								SPD_W'($urandom), SPD_W'($urandom));
					end
					if ($urandom_range(0, 3) == 0) begin
						send_item(CMD_TARGET, 1'($urandom), 1'($urandom),
								pick_target(), pick_target());
						sent++;
					end
					send_item(CMD_TICK, 1'($urandom), 1'($urandom),
							SPD_W'($urandom), SPD_W'($urandom));
					sent += burst + 1;
					quiet = 1'b0;
				end else if (pick < 82) begin
					send_item(CMD_TARGET, 1'($urandom), 1'($urandom), pick_target(), pick_target());
					sent++;
				end else if (pick < 90) begin
					// Noise the core must ignore
					send_item(CMD_UNKNOWN, 1'($urandom), 1'($urandom),
							SPD_W'($urandom), SPD_W'($urandom));
				end else if (pick < 97) begin
					send_item(CMD_TICK, 1'($urandom), 1'($urandom),
							SPD_W'($urandom), SPD_W'($urandom));
					sent++;
				end else begin
					// Pause input until the result side has caught up
					drain();
				end
			end
		end

		drain();
		if (mismatches == 0 && expected_drives.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
